/* rtl/core/wsdf_pkg.sv */
// Shared types and constants for the WebSocket frame deframer.
package wsdf_pkg;

    localparam int LEN_W = 25;   // payload length and limit width

    // Result kinds
    localparam logic [1:0] KIND_DATA     = 2'd0;
    localparam logic [1:0] KIND_EMPTY    = 2'd1;
    localparam logic [1:0] KIND_UNMASKED = 2'd2;
    localparam logic [1:0] KIND_OVERSIZE = 2'd3;

    localparam logic [3:0] OPCODE_CLOSE = 4'h8;
    localparam logic [6:0] LEN_EXT16    = 7'd126;
    localparam logic [6:0] LEN_EXT64    = 7'd127;
    localparam logic [3:0] LEN_BYTES16  = 4'd2;
    localparam logic [3:0] LEN_BYTES64  = 4'd8;
    localparam logic [2:0] MASK_BYTES   = 3'd4;

    localparam logic [LEN_W-1:0] MAX_PAYLOAD_RESET = 25'd1048576;

    // One result item
    typedef struct packed {
        logic [1:0] result_kind;
        logic [7:0] data_byte;
        logic [3:0] frame_opcode_out;
        logic       fin_out;
        logic       last_of_frame;
    } result_t;

    // Parser output towards the result register
    typedef struct packed {
        logic    valid;
        result_t item;
    } step_t;

endpackage

/* rtl/core/wsdf_if.sv */
// Channel interfaces: received byte stream and result stream.
interface wsdf_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface wsdf_result_if;
    logic       valid;
    logic       ready;
    logic [1:0] result_kind;
    logic [7:0] data_byte;
    logic [3:0] frame_opcode_out;
    logic       fin_out;
    logic       last_of_frame;

    modport source (output valid, output result_kind, output data_byte,
                    output frame_opcode_out, output fin_out, output last_of_frame,
                    input ready);
    modport sink   (input valid, input result_kind, input data_byte,
                    input frame_opcode_out, input fin_out, input last_of_frame,
                    output ready);
endinterface

/* rtl/core/wsdf_parser.sv */
// Frame header, length, mask and payload parser with the length limit register.
module wsdf_parser
    import wsdf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_fire,
    input  logic [7:0]       rx_byte,
    input  logic             cfg_we,
    input  logic [LEN_W-1:0] cfg_wdata,
    output step_t            step
);

    typedef enum logic [2:0] {
        PH_HDR0,
        PH_HDR1,
        PH_LEN,
        PH_MASK,
        PH_PAYLOAD,
        PH_HALT
    } phase_t;

    phase_t           phase_reg, phase_next;
    logic             fin_reg, fin_next;
    logic [3:0]       opcode_reg, opcode_next;
    logic [3:0]       len_left_reg, len_left_next;
    logic [LEN_W-1:0] len_accum_reg, len_accum_next;
    logic             len_ovf_reg, len_ovf_next;
    logic [31:0]      key_reg, key_next;
    logic [2:0]       mask_left_reg, mask_left_next;
    logic [LEN_W-1:0] pay_left_reg, pay_left_next;
    logic [1:0]       mask_pos_reg, mask_pos_next;
    logic [LEN_W-1:0] max_payload_reg, max_payload_next;

    // Length check inputs, shared by short and extended lengths
    logic             chk_go;
    logic [LEN_W-1:0] chk_len;
    logic             chk_ovf;
    logic [7:0]       key_byte;

    // Key bytes are used most significant first
    assign key_byte = key_reg[{~mask_pos_reg, 3'b000} +: 8];

    // Next-state and result logic
    always_comb
    begin
        phase_next       = phase_reg;
        fin_next         = fin_reg;
        opcode_next      = opcode_reg;
        len_left_next    = len_left_reg;
        len_accum_next   = len_accum_reg;
        len_ovf_next     = len_ovf_reg;
        key_next         = key_reg;
        mask_left_next   = mask_left_reg;
        pay_left_next    = pay_left_reg;
        mask_pos_next    = mask_pos_reg;
        max_payload_next = cfg_we ? cfg_wdata : max_payload_reg;
        chk_go           = 1'b0;
        chk_len          = '0;
        chk_ovf          = 1'b0;

        step.valid                 = 1'b0;
        step.item.result_kind      = KIND_DATA;
        step.item.data_byte        = 8'd0;
        step.item.frame_opcode_out = opcode_reg;
        step.item.fin_out          = fin_reg;
        step.item.last_of_frame    = 1'b1;

        if (in_fire)
        begin
            case (phase_reg)
                PH_HDR0:
                begin
                    fin_next    = rx_byte[7];
                    opcode_next = rx_byte[3:0];
                    phase_next  = PH_HDR1;
                end
                PH_HDR1:
                begin
                    len_accum_next = '0;
                    len_ovf_next   = 1'b0;
                    if (!rx_byte[7])
                    begin
                        step.valid            = 1'b1;
                        step.item.result_kind = KIND_UNMASKED;
                        phase_next            = PH_HALT;
                    end
                    else if (rx_byte[6:0] == LEN_EXT16)
                    begin
                        len_left_next = LEN_BYTES16;
                        phase_next    = PH_LEN;
                    end
                    else if (rx_byte[6:0] == LEN_EXT64)
                    begin
                        len_left_next = LEN_BYTES64;
                        phase_next    = PH_LEN;
                    end
                    else
                    begin
                        len_accum_next = {{(LEN_W-7){1'b0}}, rx_byte[6:0]};
                        len_left_next  = 4'd0;
                        chk_go         = 1'b1;
                        chk_len        = {{(LEN_W-7){1'b0}}, rx_byte[6:0]};
                    end
                end
                PH_LEN:
                begin
                    // bits shifted out above the limit width make the frame oversize
                    len_accum_next = {len_accum_reg[LEN_W-9:0], rx_byte};
                    len_ovf_next   = len_ovf_reg | (|len_accum_reg[LEN_W-1:LEN_W-8]);
                    len_left_next  = len_left_reg - 4'd1;
                    if (len_left_next == 4'd0)
                    begin
                        chk_go  = 1'b1;
                        chk_len = len_accum_next;
                        chk_ovf = len_ovf_next;
                    end
                end
                PH_MASK:
                begin
                    key_next       = {key_reg[23:0], rx_byte};
                    mask_left_next = mask_left_reg - 3'd1;
                    if (mask_left_next == 3'd0)
                    begin
                        mask_pos_next = 2'd0;
                        if (pay_left_reg == '0)
                        begin
                            step.valid            = 1'b1;
                            step.item.result_kind = KIND_EMPTY;
                            phase_next = (opcode_reg == OPCODE_CLOSE) ? PH_HALT : PH_HDR0;
                        end
                        else
                        begin
                            phase_next = PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD:
                begin
                    mask_pos_next           = mask_pos_reg + 2'd1;
                    pay_left_next           = pay_left_reg - LEN_W'(1);
                    step.valid              = 1'b1;
                    step.item.result_kind   = KIND_DATA;
                    step.item.data_byte     = rx_byte ^ key_byte;
                    step.item.last_of_frame = (pay_left_next == '0);
                    if (pay_left_next == '0)
                    begin
                        phase_next = (opcode_reg == OPCODE_CLOSE) ? PH_HALT : PH_HDR0;
                    end
                end
                default:
                begin
                    phase_next = PH_HALT;
                end
            endcase

            // Full length known: limit check, then expect the mask key
            if (chk_go)
            begin
                if (chk_ovf || (chk_len > max_payload_reg))
                begin
                    step.valid            = 1'b1;
                    step.item.result_kind = KIND_OVERSIZE;
                    phase_next            = PH_HALT;
                end
                else
                begin
                    pay_left_next  = chk_len;
                    key_next       = '0;
                    mask_left_next = MASK_BYTES;
                    phase_next     = PH_MASK;
                end
            end
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_HDR0;
            fin_reg         <= 1'b0;
            opcode_reg      <= 4'd0;
            len_left_reg    <= 4'd0;
            len_accum_reg   <= '0;
            len_ovf_reg     <= 1'b0;
            key_reg         <= '0;
            mask_left_reg   <= 3'd0;
            pay_left_reg    <= '0;
            mask_pos_reg    <= 2'd0;
            max_payload_reg <= MAX_PAYLOAD_RESET;
        end
        else
        begin
            phase_reg       <= phase_next;
            fin_reg         <= fin_next;
            opcode_reg      <= opcode_next;
            len_left_reg    <= len_left_next;
            len_accum_reg   <= len_accum_next;
            len_ovf_reg     <= len_ovf_next;
            key_reg         <= key_next;
            mask_left_reg   <= mask_left_next;
            pay_left_reg    <= pay_left_next;
            mask_pos_reg    <= mask_pos_next;
            max_payload_reg <= max_payload_next;
        end
    end

endmodule

/* rtl/core/wsdf_out_reg.sv */
// Result register: holds one result item and drives the result channel.
module wsdf_out_reg
    import wsdf_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  step_t  step,
    output logic   can_load,
    wsdf_result_if.source res
);

    logic    valid_reg, valid_next;
    result_t item_reg;

    // Free when empty or being drained this cycle
    assign can_load   = !valid_reg || res.ready;
    assign valid_next = step.valid || (valid_reg && !res.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset
    always_ff @(posedge clk)
    begin
        if (step.valid)
        begin
            item_reg <= step.item;
        end
    end

    assign res.valid            = valid_reg;
    assign res.result_kind      = item_reg.result_kind;
    assign res.data_byte        = item_reg.data_byte;
    assign res.frame_opcode_out = item_reg.frame_opcode_out;
    assign res.fin_out          = item_reg.fin_out;
    assign res.last_of_frame    = item_reg.last_of_frame;

endmodule

/* rtl/core/websocket_frame_deframer_top.sv */
// Top level of the WebSocket client-to-server frame deframer.
// A result item appears in the cycle after the byte that causes it is accepted.
// Throughput: one byte item per cycle; rx.ready only drops while a result waits
// in the output register and res.ready is low.
// Reset (rst_n, asynchronous, active low): expects a first header byte, the
// length limit returns to 1048576 and the output register empties.
module websocket_frame_deframer_top
    import wsdf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    wsdf_byte_if.sink        rx,
    wsdf_result_if.source    res,
    input  logic             cfg_we,
    input  logic [LEN_W-1:0] cfg_wdata
);

    step_t step;
    logic  can_load;
    logic  in_fire;

    assign rx.ready = can_load;
    assign in_fire  = rx.valid && can_load;

    // Parser
    wsdf_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .rx_byte   (rx.rx_byte),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .step      (step)
    );

    // Result register
    wsdf_out_reg u_out_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .can_load (can_load),
        .res      (res)
    );

endmodule

/* rtl/core/wsdf_checker.sv */
// Port-level checks for the deframer, bound to the top level.
module wsdf_checker
    import wsdf_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       rx_ready,
    input logic       res_valid,
    input logic       res_ready,
    input logic [1:0] result_kind,
    input logic [7:0] data_byte,
    input logic       last_of_frame
);

    // A pending result is not withdrawn
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result item dropped while stalled");

    // Non-data results carry no byte and close the frame
    a_nondata_form: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (result_kind != KIND_DATA) |-> (data_byte == 8'd0) && last_of_frame)
        else $error("malformed non-data result item");

    // An empty output register never stalls the input
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !res_valid |-> rx_ready)
        else $error("input stalled with output register empty");

    // Nothing follows a delivered error
    a_halt_after_error: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ready
        && ((result_kind == KIND_UNMASKED) || (result_kind == KIND_OVERSIZE))
        |=> !res_valid)
        else $error("result item after an error");

endmodule

bind websocket_frame_deframer_top wsdf_checker u_wsdf_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .rx_ready      (rx.ready),
    .res_valid     (res.valid),
    .res_ready     (res.ready),
    .result_kind   (res.result_kind),
    .data_byte     (res.data_byte),
    .last_of_frame (res.last_of_frame)
);
